// File: rtl/pcrd_pkg.sv
// Package for the periodic change report detector: widths, codes, config record and reset values.
`default_nettype none
package pcrd_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int SAMPLE_W       = 32;
   localparam int PERIOD_W       = 16;
   localparam int BAND_W         = 31;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;
   // headroom for sample +/- band and threshold compares
   localparam int WIDE_W         = 34;

   typedef enum logic [1:0] {
      MODE_AUTO,
      MODE_NOT_EQUAL,
      MODE_DEADBAND,
      MODE_THRESHOLD
   } mode_type;

   typedef enum logic [1:0] {
      EDGE_RISING,
      EDGE_FALLING,
      EDGE_BOTH
   } edge_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE,
      REG_PERIOD,
      REG_BAND,
      REG_THRESHOLD,
      REG_EDGE,
      REG_ENABLE
   } reg_index_type;

   typedef struct packed {
      mode_type                    mode;
      logic [PERIOD_W-1:0]         period;
      logic [BAND_W-1:0]           band;
      logic signed [SAMPLE_W-1:0]  threshold;
      edge_type                    edge_sel;
      logic                        enable;
   } cfg_type;

   localparam mode_type                   MODE_RESET      = MODE_NOT_EQUAL;
   localparam logic [PERIOD_W-1:0]        PERIOD_RESET    = 16'd10;
   localparam logic [BAND_W-1:0]          BAND_RESET      = 31'd10;
   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 32'sd0;
   localparam edge_type                   EDGE_RESET      = EDGE_BOTH;
   localparam logic                       ENABLE_RESET    = 1'b1;

endpackage
`default_nettype wire

// File: rtl/pcrd_csr.sv
// Configuration register file of the periodic change report detector.
`default_nettype none
module pcrd_csr
   import pcrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg,
   output logic                       restart
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
   // mode or period rewrite restarts the tick counter
   assign restart   = csr_valid && (csr_index inside {REG_MODE, REG_PERIOD});

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= MODE_RESET;
         cfg_ff.period    <= PERIOD_RESET;
         cfg_ff.band      <= BAND_RESET;
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.edge_sel  <= EDGE_RESET;
         cfg_ff.enable    <= ENABLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODE:      cfg_ff.mode      <= mode_type'(csr_data[1:0]);
            REG_PERIOD:    cfg_ff.period    <= csr_data[PERIOD_W-1:0];
            REG_BAND:      cfg_ff.band      <= csr_data[BAND_W-1:0];
            REG_THRESHOLD: cfg_ff.threshold <= $signed(csr_data[SAMPLE_W-1:0]);
            REG_EDGE:      cfg_ff.edge_sel  <= edge_type'(csr_data[1:0]);
            REG_ENABLE:    cfg_ff.enable    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/pcrd_core.sv
// Period counter, last reported value and report rule evaluation.
`default_nettype none
module pcrd_core
   import pcrd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cfg_type                      cfg,
   input  wire logic                         restart,
   input  wire logic                         step,
   input  wire logic signed [VALUE_BITS-1:0] sample,
   output logic                              report
);

   logic [PERIOD_W-1:0]         tick_count_ff, tick_count_in;
   logic signed [VALUE_BITS-1:0] last_reported_ff, last_reported_in;

   logic [PERIOD_W-1:0]       period_eff;
   logic [PERIOD_W:0]         tick_inc;
   logic                      fire;
   logic signed [WIDE_W-1:0]  aval_w, last_w, band_w, thr_w;
   logic                      rise, fall, hit;

   always_comb begin
      period_eff = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
      tick_inc   = {1'b0, tick_count_ff} + (PERIOD_W+1)'(1);
      fire       = tick_inc >= {1'b0, period_eff};

      aval_w = WIDE_W'(sample);
      last_w = WIDE_W'(last_reported_ff);
      band_w = $signed({{(WIDE_W-BAND_W){1'b0}}, cfg.band});
      thr_w  = WIDE_W'(cfg.threshold);

      rise = (last_w <= thr_w) && (aval_w > thr_w);
      fall = (last_w > thr_w) && (aval_w <= thr_w);

      hit = 1'b0;
      case (cfg.mode)
         MODE_AUTO:      hit = 1'b1;
         MODE_NOT_EQUAL: hit = aval_w != last_w;
         MODE_DEADBAND:  hit = ((last_w > aval_w + band_w) || (last_w < aval_w - band_w))
                               && (aval_w >= band_w);
         MODE_THRESHOLD: hit = (rise && (cfg.edge_sel inside {EDGE_RISING, EDGE_BOTH})) ||
                               (fall && (cfg.edge_sel inside {EDGE_FALLING, EDGE_BOTH}));
         default:        hit = 1'b0;
      endcase

      report           = cfg.enable && fire && hit;
      tick_count_in    = tick_count_ff;
      last_reported_in = last_reported_ff;
      if (step && cfg.enable) begin
         tick_count_in = fire ? '0 : tick_inc[PERIOD_W-1:0];
         if (fire && (hit || (cfg.mode == MODE_THRESHOLD))) begin
            last_reported_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff    <= '0;
         last_reported_ff <= VALUE_BITS'(1);
      end else begin
         tick_count_ff    <= restart ? '0 : tick_count_in;
         last_reported_ff <= last_reported_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/periodic_change_report_detector.sv
// Top level of the periodic change report detector: request register, core, result register.
// Path: an accepted request is held in the request register, then moves through the core into the
// result register, where it is presented until it is taken.
// Throughput: one request per cycle; the request register advances whenever the result
// register is empty or being taken, so a held result stalls the input once both are full.
// Reset: synchronous, active high; clears the counter, sets the last reported value to 1
// and loads the configuration registers with their defaults.
`default_nettype none
module periodic_change_report_detector
   import pcrd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_report_now,
   output logic signed [SAMPLE_W-1:0]       rsp_reported_value,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_data
);

   cfg_type cfg;
   logic    restart;
   logic    advance;
   logic    report;

   logic                         in_valid_ff;
   logic signed [VALUE_BITS-1:0] in_sample_ff;
   logic                         out_valid_ff;
   logic                         out_report_ff;
   logic signed [SAMPLE_W-1:0]   out_value_ff;

   pcrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .restart   (restart)
   );

   pcrd_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .restart (restart),
      .step    (advance),
      .sample  (in_sample_ff),
      .report  (report)
   );

   assign advance            = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready          = !in_valid_ff || advance;
   assign rsp_valid          = out_valid_ff;
   assign rsp_report_now     = out_report_ff;
   assign rsp_reported_value = out_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= $signed(req_sample_value[VALUE_BITS-1:0]);
      end
      if (advance) begin
         out_report_ff <= report;
         out_value_ff  <= SAMPLE_W'(in_sample_ff);
      end
   end

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for the periodic change report detector: directed and random requests against a predictor.
module testbench
   import pcrd_pkg::*;
();

   localparam int CLOCK_PERIOD      = 8;
   localparam int RESET_CYCLES      = 5;
   localparam int DRAIN_SLACK       = 4;
   localparam int STALL_LIMIT       = 2000;
   localparam int HOLD_CYCLES       = 150;
   localparam int ITEMS_PER_SETTING = 40;

   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
   localparam logic [1:0]           EDGE_UNUSED  = 2'd3;

   typedef struct {
      logic                       report;
      logic signed [SAMPLE_W-1:0] value;
   } report_rec_type;

   class report_scoreboard;
      mode_type                   mode;
      logic [PERIOD_W-1:0]        period;
      logic [BAND_W-1:0]          band;
      logic signed [SAMPLE_W-1:0] level;
      logic [1:0]                 edge_code;
      logic                       enable;
      logic [PERIOD_W-1:0]        ticks;
      logic signed [SAMPLE_W-1:0] last_val;
      report_rec_type             due_reports[$];
      int                         errors;

      function new();
         mode      = MODE_RESET;
         period    = PERIOD_RESET;
         band      = BAND_RESET;
         level     = THRESHOLD_RESET;
         edge_code = EDGE_RESET;
         enable    = ENABLE_RESET;
         ticks     = '0;
         last_val  = 1;
         errors    = 0;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_MODE: begin
               mode  = mode_type'(data[1:0]);
               ticks = '0;
            end
            REG_PERIOD: begin
               period = data[PERIOD_W-1:0];
               ticks  = '0;
            end
            REG_BAND:      band      = data[BAND_W-1:0];
            REG_THRESHOLD: level     = $signed(data);
            REG_EDGE:      edge_code = data[1:0];
            REG_ENABLE:    enable    = data[0];
            default: ;
         endcase
      endfunction

      // one tick: when enabled, advance the period counter and evaluate the rule on a firing
      function void predict_report(logic signed [SAMPLE_W-1:0] sample);
         longint         s, l, b, t;
         logic [16:0]    next;
         logic           fire, hit, rise, fall;
         report_rec_type rec;
         hit = 1'b0;
         if (enable) begin
            next  = ticks + 17'd1;
            fire  = next >= ((period == '0) ? 17'd1 : {1'b0, period});
            ticks = fire ? '0 : next[PERIOD_W-1:0];
            if (fire) begin
               s = longint'(sample);
               l = longint'(last_val);
               b = longint'(band);
               t = longint'(level);
               case (mode)
                  MODE_AUTO: begin
                     hit      = 1'b1;
                     last_val = sample;
                  end
                  MODE_NOT_EQUAL: begin
                     if (s != l) begin
                        hit      = 1'b1;
                        last_val = sample;
                     end
                  end
                  MODE_DEADBAND: begin
                     if ((l > s + b || l < s - b) && s >= b) begin
                        hit      = 1'b1;
                        last_val = sample;
                     end
                  end
                  default: begin
                     rise     = l <= t && s > t;
                     fall     = l > t && s <= t;
                     last_val = sample;
                     hit = (rise && (edge_code == EDGE_RISING || edge_code == EDGE_BOTH)) ||
                           (fall && (edge_code == EDGE_FALLING || edge_code == EDGE_BOTH));
                  end
               endcase
            end
         end
         rec.report = hit;
         rec.value  = sample;
         due_reports.push_back(rec);
      endfunction

      function void check_report(logic report, logic signed [SAMPLE_W-1:0] value);
         report_rec_type rec;
         if (due_reports.size() == 0) begin
            $error("result with no request outstanding: report_now %0d value %0d",
                   report, value);
            errors++;
            return;
         end
         rec = due_reports.pop_front();
         if (report !== rec.report) begin
            $error("report_now: expected %0d, got %0d", rec.report, report);
            errors++;
         end
         if (value !== rec.value) begin
            $error("reported_value: expected %0d, got %0d", rec.value, value);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_reports.size();
      endfunction

      function void close_out();
         if (due_reports.size() != 0) begin
            $error("%0d results never arrived", due_reports.size());
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_report_now;
   logic signed [SAMPLE_W-1:0] rsp_reported_value;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   report_scoreboard           sb = new();
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;
   bit                         hold_off = 1'b0;
   logic signed [SAMPLE_W-1:0] last_sent = '0;
   logic [BAND_W-1:0]          cur_band = BAND_RESET;
   logic signed [SAMPLE_W-1:0] cur_level = THRESHOLD_RESET;

   periodic_change_report_detector u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_report_now     (rsp_report_now),
      .rsp_reported_value (rsp_reported_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.apply_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.predict_report(req_sample_value);
         if (rsp_valid && rsp_ready)
            sb.check_report(rsp_report_now, rsp_reported_value);
      end
   end

   // receiver; a long hold-off lets the block fill and stall its input
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
      req_valid        <= 1'b1;
      req_sample_value <= v;
      last_sent = v;
      do @(posedge clock); while (!req_ready);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic drive_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // new setting; unused upper data bits are random
   task automatic random_setting(input bit all_regs);
      logic [CSR_DATA_W-1:0] d;
      int                    r;
      if (all_regs || $urandom_range(9) < 7) begin
         d      = $urandom;
         d[1:0] = 2'($urandom_range(3));
         drive_reg(REG_MODE, d);
      end
      if (all_regs || $urandom_range(9) < 7) begin
         d = $urandom;
         r = $urandom_range(19);
         d[PERIOD_W-1:0] = PERIOD_W'((r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                           (r == 2) ? $urandom_range(60, 5) : $urandom_range(3, 1));
         drive_reg(REG_PERIOD, d);
      end
      if (all_regs || $urandom_range(9) < 7) begin
         d = $urandom;
         r = $urandom_range(9);
         d[BAND_W-1:0] = BAND_W'((r == 0) ? '0 : (r == 1) ? 31'h7FFFFFFF :
                         (r == 2) ? $urandom : $urandom_range(20));
         cur_band = d[BAND_W-1:0];
         drive_reg(REG_BAND, d);
      end
      if (all_regs || $urandom_range(9) < 7) begin
         r = $urandom_range(9);
         d = (r == 0) ? 32'h80000000 : (r == 1) ? 32'h7FFFFFFF :
             (r == 2) ? $urandom : $urandom_range(40) - 20;
         cur_level = $signed(d);
         drive_reg(REG_THRESHOLD, d);
      end
      if (all_regs || $urandom_range(9) < 7) begin
         d      = $urandom;
         d[1:0] = 2'($urandom_range(3));
         drive_reg(REG_EDGE, d);
      end
      if (all_regs || $urandom_range(9) < 7) begin
         d    = $urandom;
         d[0] = ($urandom_range(9) != 0);
         drive_reg(REG_ENABLE, d);
      end
      if ($urandom_range(3) == 0)
         drive_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, $urandom);
   endtask

   // mostly walks near the last sample or the level, with repeats and extremes
   function automatic logic signed [SAMPLE_W-1:0] next_sample();
      int                         span;
      logic signed [SAMPLE_W-1:0] v;
      span = (cur_band > 1000) ? 1000 : int'(cur_band) + 4;
      case ($urandom_range(9))
         0: v = $urandom;
         1: begin
            case ($urandom_range(3))
               0:       v = 32'sh7FFFFFFF;
               1:       v = 32'sh80000000;
               2:       v = '0;
               default: v = -32'sd1;
            endcase
         end
         2, 3:    v = last_sent;
         4, 5:    v = cur_level + $urandom_range(6) - 3;
         default: v = last_sent + $urandom_range(2 * span) - span;
      endcase
      return v;
   endfunction

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_sample_value <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= REG_MODE;
      csr_data         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: counter runs, no firing yet
      send_sample(32'sh7FFFFFFF);
      send_sample(32'sh80000000);
      send_sample(32'sh0);
      send_sample(-32'sd1);

      // period of zero fires every tick
      quiesce();
      drive_reg(REG_MODE, MODE_AUTO);
      drive_reg(REG_PERIOD, 32'd0);
      send_sample(32'sd1);
      send_sample(32'sh80000000);

      quiesce();
      drive_reg(REG_MODE, MODE_NOT_EQUAL);
      drive_reg(REG_PERIOD, 32'd1);
      send_sample(32'sh80000000);
      send_sample(32'sd5);
      send_sample(32'sd5);

      quiesce();
      drive_reg(REG_MODE, MODE_DEADBAND);
      drive_reg(REG_BAND, 32'd3);
      send_sample(32'sd9);
      send_sample(32'sd11);
      send_sample(32'sd2);
      quiesce();
      drive_reg(REG_BAND, 32'h7FFFFFFF);
      send_sample(32'sh7FFFFFFF);
      quiesce();
      drive_reg(REG_BAND, 32'h80000000);
      send_sample(32'sd9);
      send_sample(32'sd10);

      quiesce();
      drive_reg(REG_MODE, MODE_THRESHOLD);
      drive_reg(REG_THRESHOLD, 32'd0);
      drive_reg(REG_EDGE, EDGE_RISING);
      send_sample(-32'sd1);
      send_sample(32'sd1);
      send_sample(-32'sd1);
      quiesce();
      drive_reg(REG_EDGE, EDGE_FALLING);
      send_sample(32'sd1);
      send_sample(-32'sd1);
      quiesce();
      drive_reg(REG_EDGE, EDGE_UNUSED);
      send_sample(32'sd1);
      quiesce();
      drive_reg(REG_THRESHOLD, 32'h7FFFFFFF);
      send_sample(32'sh7FFFFFFF);
      quiesce();
      drive_reg(REG_THRESHOLD, 32'h80000000);
      drive_reg(REG_EDGE, EDGE_BOTH);
      send_sample(32'sh80000000);

      // disabled: no report, state held
      quiesce();
      drive_reg(REG_ENABLE, 32'd0);
      send_sample(32'sd3);
      send_sample(32'sd4);
      quiesce();
      drive_reg(REG_ENABLE, 32'hFFFFFFFF);
      drive_reg(IDX_SPARE_LO, $urandom);
      drive_reg(IDX_SPARE_HI, $urandom);
      send_sample(32'sd3);

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int st = 0; st < 4; st++) begin
            quiesce();
            random_setting(st == 0);
            for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
               if (ph == 2 && st == 1 && i == 5)
                  hold_off = 1'b1;
               send_sample(next_sample());
            end
         end
      end

      quiesce();
      sb.close_out();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
